// ===== rtl/core/qte_pkg.sv =====
package qte_pkg;

  // CORDIC depth and the size of the micro-rotation table.
  localparam int CORDIC_STAGES    = 16;
  localparam int ANGLE_TABLE_SIZE = 24;
  localparam int CORDIC_RUN       = (CORDIC_STAGES < ANGLE_TABLE_SIZE) ?
                                    CORDIC_STAGES : ANGLE_TABLE_SIZE;

  // Square root: one result bit per stage, 31 bits of root.
  localparam int SQRT_STEPS = 31;
  localparam int SQ_W       = 62;

  // Q.30 numerator/denominator width and CORDIC datapath width.
  localparam int NUM_W = 34;
  localparam int VW    = 36;

  // Lanes of the CORDIC array.
  localparam int LANES      = 3;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic signed [15:0] PITCH_MAX = 16'sd16384;

  typedef logic signed [15:0] q15_t;
  typedef logic signed [15:0] angle_t;

  // atan(2^-i) as a 32-bit binary angle, rounded to nearest.
  localparam logic [31:0] ATAN_STEPS [ANGLE_TABLE_SIZE] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

// ===== rtl/core/qte_if.sv =====
interface qte_in_if;
  import qte_pkg::*;
  logic valid;
  logic ready;
  q15_t quat_w;
  q15_t quat_x;
  q15_t quat_y;
  q15_t quat_z;
  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

interface qte_out_if;
  import qte_pkg::*;
  logic   valid;
  logic   ready;
  angle_t roll_angle;
  angle_t pitch_angle;
  angle_t yaw_angle;
  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle,
                  input yaw_angle, output ready);
endinterface

// ===== rtl/core/quaternion_to_euler_top.sv =====
// Quaternion to ZYX Euler angle converter.
// Input channel in_ch carries one unit quaternion (w, x, y, z) per item in
// signed Q1.15. Output channel out_ch carries roll, pitch and yaw per item as
// signed 16-bit binary angles (32768 is pi); pitch stays within +/-pi/2.
// Both channels use valid/ready; an item moves when both are high.
// Throughput: one item per cycle. The pipeline is fully stalled only while a
// result sits in the output register and out_ch.ready is low; in_ch.ready is
// high whenever the output register is empty or being taken.
// Pipeline, from acceptance to out_ch.valid: input register, products, sums,
// the square of the asin argument, 31 square-root stages (one root bit each),
// quadrant fold, one stage per CORDIC micro-rotation for all three angles
// side by side, and the output register.
// A stall holds every stage in place, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; items in flight are
// dropped and the block is ready on the next cycle.
module quaternion_to_euler_top (
  input  logic      clk,
  input  logic      rst_n,
  qte_in_if.sink    in_ch,
  qte_out_if.source out_ch
);
  import qte_pkg::*;

  logic en;

  // Stage 0: input register.
  logic v0_r;
  q15_t w0_r, x0_r, y0_r, z0_r;
  // Stage 1: products, Q2.30.
  logic v1_r;
  logic signed [31:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wz_r, p_xy_r;
  logic signed [31:0] p_zz_r, p_wy_r, p_xz_r;
  // Stage 2: numerators, denominators, clamped asin argument.
  logic v2_r;
  logic signed [NUM_W-1:0] rn2_r, rd2_r, yn2_r, yd2_r;
  logic signed [31:0] s2_r;
  logic signed [NUM_W-1:0] rn_c, rd_c, yn_c, yd_c, s_c;
  // Stage 3: radicand of the square root.
  logic v3_r;
  logic signed [NUM_W-1:0] rn3_r, rd3_r, yn3_r, yd3_r;
  logic signed [31:0] s3_r;
  logic [60:0] n3_r;
  logic signed [63:0] ss_c;
  // Square-root stages.
  logic            sq_v_r    [SQRT_STEPS];
  logic [SQ_W-1:0] sq_rem_r  [SQRT_STEPS];
  logic [SQ_W-1:0] sq_root_r [SQRT_STEPS];
  logic [SQ_W-1:0] sq_rem_in [SQRT_STEPS];
  logic [SQ_W-1:0] sq_root_in[SQRT_STEPS];
  logic [SQ_W-1:0] sq_rem_nxt [SQRT_STEPS];
  logic [SQ_W-1:0] sq_root_nxt[SQRT_STEPS];
  logic signed [NUM_W-1:0] sq_rn_r[SQRT_STEPS], sq_rd_r[SQRT_STEPS];
  logic signed [NUM_W-1:0] sq_yn_r[SQRT_STEPS], sq_yd_r[SQRT_STEPS];
  logic signed [31:0]      sq_s_r [SQRT_STEPS];
  // CORDIC stages; index 0 is the quadrant fold.
  logic                 cv_r [CORDIC_RUN+1];
  logic signed [VW-1:0] cx_r [CORDIC_RUN+1][LANES];
  logic signed [VW-1:0] cy_r [CORDIC_RUN+1][LANES];
  logic [31:0]          ca_r [CORDIC_RUN+1][LANES];
  logic                 cz_r [CORDIC_RUN+1][LANES];
  logic signed [VW-1:0] vx_in [LANES];
  logic signed [VW-1:0] vy_in [LANES];
  logic signed [VW-1:0] cx_nxt [CORDIC_RUN][LANES];
  logic signed [VW-1:0] cy_nxt [CORDIC_RUN][LANES];
  logic [31:0]          ca_nxt [CORDIC_RUN][LANES];
  // Output register.
  logic   out_valid_r;
  angle_t roll_r, pitch_r, yaw_r;
  angle_t ang_c [LANES];
  angle_t pitch_c;

  // The whole pipeline advances unless a result waits on a stalled receiver.
  assign en          = ~out_valid_r | out_ch.ready;
  assign in_ch.ready = en;

  // Sums of products, doubled; asin argument clamped to +/-1.0.
  always_comb begin
    rn_c = (NUM_W'(p_wx_r) + NUM_W'(p_yz_r)) <<< 1;
    yn_c = (NUM_W'(p_wz_r) + NUM_W'(p_xy_r)) <<< 1;
    rd_c = NUM_W'(34'sh40000000) - ((NUM_W'(p_xx_r) + NUM_W'(p_yy_r)) <<< 1);
    yd_c = NUM_W'(34'sh40000000) - ((NUM_W'(p_yy_r) + NUM_W'(p_zz_r)) <<< 1);
    s_c  = (NUM_W'(p_wy_r) - NUM_W'(p_xz_r)) <<< 1;
    if (s_c > NUM_W'(34'sh40000000)) begin
      s_c = NUM_W'(34'sh40000000);
    end else if (s_c < -NUM_W'(34'sh40000000)) begin
      s_c = -NUM_W'(34'sh40000000);
    end
  end

  assign ss_c = s2_r * s2_r;

  // One restoring square-root step per stage, bit walking down from 2^60.
  always_comb begin
    sq_rem_in[0]  = {1'b0, n3_r};
    sq_root_in[0] = '0;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      sq_rem_in[k]  = sq_rem_r[k-1];
      sq_root_in[k] = sq_root_r[k-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (sq_rem_in[k] >= sq_root_in[k] + (SQ_W'(1) << (60 - 2 * k))) begin
        sq_rem_nxt[k]  = sq_rem_in[k] - (sq_root_in[k] + (SQ_W'(1) << (60 - 2 * k)));
        sq_root_nxt[k] = (sq_root_in[k] >> 1) + (SQ_W'(1) << (60 - 2 * k));
      end else begin
        sq_rem_nxt[k]  = sq_rem_in[k];
        sq_root_nxt[k] = sq_root_in[k] >> 1;
      end
    end
  end

  // Vectors entering the CORDIC array.
  always_comb begin
    vy_in[LANE_ROLL]  = VW'(sq_rn_r[SQRT_STEPS-1]);
    vx_in[LANE_ROLL]  = VW'(sq_rd_r[SQRT_STEPS-1]);
    vy_in[LANE_PITCH] = VW'(sq_s_r[SQRT_STEPS-1]);
    vx_in[LANE_PITCH] = VW'({1'b0, sq_root_r[SQRT_STEPS-1][30:0]});
    vy_in[LANE_YAW]   = VW'(sq_yn_r[SQRT_STEPS-1]);
    vx_in[LANE_YAW]   = VW'(sq_yd_r[SQRT_STEPS-1]);
  end

  // Micro-rotations toward the positive x axis.
  always_comb begin
    for (int i = 0; i < CORDIC_RUN; i++) begin
      for (int l = 0; l < LANES; l++) begin
        if (!cy_r[i][l][VW-1]) begin
          cx_nxt[i][l] = cx_r[i][l] + (cy_r[i][l] >>> i);
          cy_nxt[i][l] = cy_r[i][l] - (cx_r[i][l] >>> i);
          ca_nxt[i][l] = ca_r[i][l] + ATAN_STEPS[i];
        end else begin
          cx_nxt[i][l] = cx_r[i][l] - (cy_r[i][l] >>> i);
          cy_nxt[i][l] = cy_r[i][l] + (cx_r[i][l] >>> i);
          ca_nxt[i][l] = ca_r[i][l] - ATAN_STEPS[i];
        end
      end
    end
  end

  // Rounding to 16 bits; a zero vector gives angle zero; pitch clamped.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ang_c[l] = cz_r[CORDIC_RUN][l] ? '0 :
                 angle_t'((ca_r[CORDIC_RUN][l] + 32'h00008000) >> 16);
    end
    pitch_c = ang_c[LANE_PITCH];
    if (pitch_c > PITCH_MAX) begin
      pitch_c = PITCH_MAX;
    end else if (pitch_c < -PITCH_MAX) begin
      pitch_c = -PITCH_MAX;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < SQRT_STEPS; k++) sq_v_r[k] <= 1'b0;
      for (int i = 0; i <= CORDIC_RUN; i++) cv_r[i] <= 1'b0;
    end else if (en) begin
      v0_r      <= in_ch.valid;
      v1_r      <= v0_r;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      sq_v_r[0] <= v3_r;
      for (int k = 1; k < SQRT_STEPS; k++) sq_v_r[k] <= sq_v_r[k-1];
      cv_r[0] <= sq_v_r[SQRT_STEPS-1];
      for (int i = 1; i <= CORDIC_RUN; i++) cv_r[i] <= cv_r[i-1];
      out_valid_r <= cv_r[CORDIC_RUN];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      w0_r <= in_ch.quat_w;
      x0_r <= in_ch.quat_x;
      y0_r <= in_ch.quat_y;
      z0_r <= in_ch.quat_z;

      p_wx_r <= w0_r * x0_r;
      p_yz_r <= y0_r * z0_r;
      p_xx_r <= x0_r * x0_r;
      p_yy_r <= y0_r * y0_r;
      p_wz_r <= w0_r * z0_r;
      p_xy_r <= x0_r * y0_r;
      p_zz_r <= z0_r * z0_r;
      p_wy_r <= w0_r * y0_r;
      p_xz_r <= x0_r * z0_r;

      rn2_r <= rn_c;
      rd2_r <= rd_c;
      yn2_r <= yn_c;
      yd2_r <= yd_c;
      s2_r  <= 32'(s_c);

      rn3_r <= rn2_r;
      rd3_r <= rd2_r;
      yn3_r <= yn2_r;
      yd3_r <= yd2_r;
      s3_r  <= s2_r;
      n3_r  <= 61'((64'd1 << 60) - 64'(ss_c));

      for (int k = 0; k < SQRT_STEPS; k++) begin
        sq_rem_r[k]  <= sq_rem_nxt[k];
        sq_root_r[k] <= sq_root_nxt[k];
      end
      sq_rn_r[0] <= rn3_r;
      sq_rd_r[0] <= rd3_r;
      sq_yn_r[0] <= yn3_r;
      sq_yd_r[0] <= yd3_r;
      sq_s_r[0]  <= s3_r;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq_rn_r[k] <= sq_rn_r[k-1];
        sq_rd_r[k] <= sq_rd_r[k-1];
        sq_yn_r[k] <= sq_yn_r[k-1];
        sq_yd_r[k] <= sq_yd_r[k-1];
        sq_s_r[k]  <= sq_s_r[k-1];
      end

      // Quadrant fold: a negative x turns the vector by pi.
      for (int l = 0; l < LANES; l++) begin
        cz_r[0][l] <= (vx_in[l] == '0) && (vy_in[l] == '0);
        if (vx_in[l][VW-1]) begin
          cx_r[0][l] <= -vx_in[l];
          cy_r[0][l] <= -vy_in[l];
          ca_r[0][l] <= 32'h80000000;
        end else begin
          cx_r[0][l] <= vx_in[l];
          cy_r[0][l] <= vy_in[l];
          ca_r[0][l] <= '0;
        end
      end

      for (int i = 0; i < CORDIC_RUN; i++) begin
        for (int l = 0; l < LANES; l++) begin
          cx_r[i+1][l] <= cx_nxt[i][l];
          cy_r[i+1][l] <= cy_nxt[i][l];
          ca_r[i+1][l] <= ca_nxt[i][l];
          cz_r[i+1][l] <= cz_r[i][l];
        end
      end

      roll_r  <= ang_c[LANE_ROLL];
      pitch_r <= pitch_c;
      yaw_r   <= ang_c[LANE_YAW];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.roll_angle  = roll_r;
  assign out_ch.pitch_angle = pitch_r;
  assign out_ch.yaw_angle   = yaw_r;

endmodule

// ===== rtl/core/qte_checker.sv =====
module qte_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [15:0]  out_roll,
  input logic signed [15:0]  out_pitch,
  input logic signed [15:0]  out_yaw
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_roll) &&
                               $stable(out_pitch) && $stable(out_yaw))
    else $error("stalled result changed");

  // Pitch never leaves +/-pi/2.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch <= 16'sd16384) && (out_pitch >= -16'sd16384))
    else $error("pitch out of range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // With no result waiting, the block takes a new item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind quaternion_to_euler_top qte_checker u_qte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_roll  (out_ch.roll_angle),
  .out_pitch (out_ch.pitch_angle),
  .out_yaw   (out_ch.yaw_angle)
);

// ===== test/qte_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the converter, predicts the Euler angles of every
// accepted quaternion and compares them with the results in order.
module qte_scoreboard (
  input  logic clk,
  input  logic rst_n,
  qte_in_if    in_mon,
  qte_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);
  import qte_pkg::*;

  typedef struct packed {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } euler_t;

  euler_t expected_angles[$];

  initial fail_count = 0;
  initial pending_count = 0;

  // Integer square root, rounded down.
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned rem, root, bitv;
    rem  = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC: angle of (x, y) as a 32-bit binary angle.
  function automatic logic [31:0] vector_phase(input longint y_in, input longint x_in);
    logic [31:0] acc;
    longint      xv, yv, dx, dy;
    acc = 32'd0;
    xv  = x_in;
    yv  = y_in;
    if (xv == 0 && yv == 0) return 32'd0;
    // Left half plane: turn by pi first.
    if (xv < 0) begin
      xv  = -xv;
      yv  = -yv;
      acc = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STAGES && i < ANGLE_TABLE_SIZE; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv  = xv + dx;
        yv  = yv - dy;
        acc = acc + ATAN_STEPS[i];
      end else begin
        xv  = xv - dx;
        yv  = yv + dy;
        acc = acc - ATAN_STEPS[i];
      end
    end
    return acc;
  endfunction

  function automatic angle_t round_angle(input logic [31:0] acc);
    logic [31:0] sum;
    sum = acc + 32'h8000;
    return angle_t'(sum[31:16]);
  endfunction

  // Roll, pitch and yaw of one quaternion.
  function automatic euler_t predict_euler(input q15_t w, input q15_t x,
                                           input q15_t y, input q15_t z);
    longint one, wl, xl, yl, zl, roll_num, roll_den, yaw_num, yaw_den, s, c;
    angle_t p;
    euler_t r;
    one = 64'sd1 << 30;
    wl = w; xl = x; yl = y; zl = z;
    roll_num = 2 * (wl * xl + yl * zl);
    roll_den = one - 2 * (xl * xl + yl * yl);
    yaw_num  = 2 * (wl * zl + xl * yl);
    yaw_den  = one - 2 * (yl * yl + zl * zl);
    s = 2 * (wl * yl - xl * zl);
    // The asin argument saturates at plus or minus one.
    if (s > one) s = one;
    if (s < -one) s = -one;
    c = longint'(int_sqrt((64'd1 << 60) - longint'(s * s)));
    p = round_angle(vector_phase(s, c));
    if (p > PITCH_MAX) p = PITCH_MAX;
    if (p < -PITCH_MAX) p = -PITCH_MAX;
    r.roll  = round_angle(vector_phase(roll_num, roll_den));
    r.pitch = p;
    r.yaw   = round_angle(vector_phase(yaw_num, yaw_den));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Queue a prediction for every accepted item and compare every result.
  always @(posedge clk) begin
    euler_t want;
    euler_t pred;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        pred = predict_euler(in_mon.quat_w, in_mon.quat_x,
                             in_mon.quat_y, in_mon.quat_z);
        expected_angles.insert(expected_angles.size(), pred);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_angles.pop_front();
          if (out_mon.roll_angle !== want.roll)
            report_mismatch($sformatf("roll %0d, expected %0d",
                                      out_mon.roll_angle, want.roll));
          if (out_mon.pitch_angle !== want.pitch)
            report_mismatch($sformatf("pitch %0d, expected %0d",
                                      out_mon.pitch_angle, want.pitch));
          if (out_mon.yaw_angle !== want.yaw)
            report_mismatch($sformatf("yaw %0d, expected %0d",
                                      out_mon.yaw_angle, want.yaw));
        end
      end
    end
    pending_count = expected_angles.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import qte_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   items_sent;
  int   cycle_count;
  bit   sender_calm;

  qte_in_if  in_ch ();
  qte_out_if out_ch ();

  quaternion_to_euler_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  qte_scoreboard u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one item, after a random gap unless sender_calm is set, and wait until it is taken.
  task automatic send_quat(input int w, input int x, input int y, input int z);
    while (!sender_calm && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.quat_w <= q15_t'(w);
    in_ch.quat_x <= q15_t'(x);
    in_ch.quat_y <= q15_t'(y);
    in_ch.quat_z <= q15_t'(z);
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic int rand_signed(input int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Random direction, scaled to unit length in Q1.15.
  task automatic send_unit_quat();
    real a, b, c, d, n;
    a = rand_signed(30000);
    b = rand_signed(30000);
    c = rand_signed(30000);
    d = rand_signed(30000);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      a = 1.0;
      n = 1.0;
    end
    send_quat(int'(a / n * 32767.0), int'(b / n * 32767.0),
              int'(c / n * 32767.0), int'(d / n * 32767.0));
  endtask

  // Receiver: random stalls, one long hold-off and one stretch without stalls.
  initial begin
    out_ch.ready = 1'b0;
    cycle_count  = 0;
    forever begin
      @(negedge clk);
      cycle_count++;
      if (cycle_count >= 300 && cycle_count < 700)
        out_ch.ready <= 1'b0;
      else if (cycle_count >= 1200 && cycle_count < 1800)
        out_ch.ready <= 1'b1;
      else
        out_ch.ready <= ($urandom_range(99) >= 17);
    end
  end

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int sel;
    in_ch.valid  = 1'b0;
    in_ch.quat_w = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    items_sent   = 0;
    sender_calm  = 1'b0;
    rst_n        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero, identity, axis turns, extremes, gimbal lock, non-unit.
    send_quat(0, 0, 0, 0);
    send_quat(32767, 0, 0, 0);
    send_quat(-32768, 0, 0, 0);
    send_quat(0, 32767, 0, 0);
    send_quat(0, -32768, 0, 0);
    send_quat(0, 0, 32767, 0);
    send_quat(0, 0, 0, 32767);
    send_quat(0, 0, 0, -32768);
    send_quat(23170, 23170, 0, 0);
    send_quat(23170, -23170, 0, 0);
    send_quat(23170, 0, 23170, 0);
    send_quat(23170, 0, -23170, 0);
    send_quat(23170, 0, 0, 23170);
    send_quat(23170, 0, 0, -23170);
    send_quat(23200, 0, 23200, 0);
    send_quat(16384, 16384, 16384, -16384);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(1, 0, 0, 0);
    send_quat(0, 1, 0, -1);
    send_quat(-1, -1, -1, -1);
    send_quat(0, 32767, 0, 32767);

    // Random: mostly unit quaternions, some near gimbal lock, some raw noise.
    for (int i = 0; i < 1700; i++) begin
      sender_calm = (i >= 1000 && i < 1300);
      if (i == 500) begin
        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
      end
      sel = $urandom_range(99);
      if (sel < 60)
        send_unit_quat();
      else if (sel < 80)
        send_quat(23170 + rand_signed(40), rand_signed(40),
                  ($urandom_range(1) ? 23170 : -23170) + rand_signed(40),
                  rand_signed(40));
      else
        send_quat(rand_signed(32768) % 32768, $urandom_range(65535) - 32768,
                  $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/qte_pkg.sv
rtl/core/qte_if.sv
rtl/core/quaternion_to_euler_top.sv
rtl/core/qte_checker.sv
test/qte_checker.sv
test/testbench.sv
